@@ hw/rtl/vau_pkg.sv @@
// ----------------------------------------------------------------------------
// vau_pkg
// Shared types, constants and the micro-rotation angle table of the
// vector angle unit.
// ----------------------------------------------------------------------------
package vau_pkg;

  // Number of micro-rotations requested, and the size of the angle table.
  localparam int ITERATIONS      = 16;
  localparam int STEP_TABLE_SIZE = 24;
  localparam int NUM_STEPS       = (ITERATIONS < STEP_TABLE_SIZE) ? ITERATIONS
                                                                  : STEP_TABLE_SIZE;
  localparam int STEP_IDX_W      = $clog2(STEP_TABLE_SIZE);

  // Input / output field widths.
  localparam int COORD_W = 16;
  localparam int TURN_W  = 16;

  // Datapath: components scaled by 2^24, |v| * gain stays below 2^42.
  localparam int SCALE_SH = 24;
  localparam int COMP_W   = 44;
  localparam int ANGLE_W  = 32;   // accumulated angle, 2^32 units per turn

  // Request in to result out: entry stage, cells, output register.
  localparam int LATENCY = NUM_STEPS + 2;

  // Axis directions as binary angles.
  localparam logic [TURN_W-1:0] ANGLE_ZERO       = TURN_W'(0);
  localparam logic [TURN_W-1:0] ANGLE_QUARTER    = TURN_W'(16384);
  localparam logic [TURN_W-1:0] ANGLE_HALF       = TURN_W'(32768);
  localparam logic [TURN_W-1:0] ANGLE_THREE_QTR  = TURN_W'(49152);
  localparam logic [ANGLE_W-1:0] ROUND_HALF      = ANGLE_W'(32768);
  localparam logic [ANGLE_W-1:0] HALF_TURN_FINE  = ANGLE_W'(64'h8000_0000);

  // One element of the rotation chain.
  typedef struct packed {
    logic                     valid;
    logic                     special;  // axis or zero vector: angle is final
    logic signed [COMP_W-1:0] cx;
    logic signed [COMP_W-1:0] cy;
    logic [ANGLE_W-1:0]       z;
  } stage_t;

  // atan(2^-i) in units of 2^-32 turn, rounded to nearest.
  function automatic logic [ANGLE_W-1:0] step_angle(input logic [STEP_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] a;
    unique case (idx)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ hw/rtl/vau_prep.sv @@
// ----------------------------------------------------------------------------
// vau_prep
// Entry stage: axis / zero detection, half-turn fold of the left half
// plane, scaling of the components.
// ----------------------------------------------------------------------------
module vau_prep (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [vau_pkg::COORD_W-1:0] x_coord,
  input  logic signed [vau_pkg::COORD_W-1:0] y_coord,
  output vau_pkg::stage_t                 head
);
  import vau_pkg::*;

  logic                    x_neg;
  logic                    x_zero;
  logic                    y_zero;
  logic signed [COORD_W:0] xs;
  logic signed [COORD_W:0] ys;
  logic signed [COORD_W:0] xa;
  logic signed [COORD_W:0] ya;
  logic [TURN_W-1:0]       axis_angle;
  stage_t                  head_next;

  always_comb begin
    x_neg  = x_coord[COORD_W-1];
    x_zero = (x_coord == '0);
    y_zero = (y_coord == '0);
    xs     = {x_coord[COORD_W-1], x_coord};
    ys     = {y_coord[COORD_W-1], y_coord};
    xa     = x_neg ? -xs : xs;
    ya     = x_neg ? -ys : ys;

    priority if (y_zero) begin
      axis_angle = x_neg ? ANGLE_HALF : ANGLE_ZERO;    // covers the zero vector
    end else if (x_zero) begin
      axis_angle = y_coord[COORD_W-1] ? ANGLE_THREE_QTR : ANGLE_QUARTER;
    end else begin
      axis_angle = ANGLE_ZERO;
    end

    // synchronous reset clears the valid bit only
    head_next.valid   = start && !rst;
    head_next.special = x_zero || y_zero;
    head_next.cx      = {{(COMP_W-COORD_W-1-SCALE_SH){xa[COORD_W]}}, xa, SCALE_SH'(0)};
    head_next.cy      = {{(COMP_W-COORD_W-1-SCALE_SH){ya[COORD_W]}}, ya, SCALE_SH'(0)};
    // Axis cases carry their final angle; the rest start from the fold base.
    if (x_zero || y_zero) begin
      head_next.z = {axis_angle, (ANGLE_W-TURN_W)'(0)};
    end else begin
      head_next.z = x_neg ? HALF_TURN_FINE : '0;
    end
  end

  always_ff @(posedge clk) begin
    head <= head_next;
  end

endmodule

@@ hw/rtl/vau_cell.sv @@
// ----------------------------------------------------------------------------
// vau_cell
// One CORDIC vectoring micro-rotation, registered.
// ----------------------------------------------------------------------------
module vau_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [vau_pkg::STEP_IDX_W-1:0]    step,
  input  vau_pkg::stage_t                   prev,
  output vau_pkg::stage_t                   curr
);
  import vau_pkg::*;

  logic signed [COMP_W-1:0] dx;
  logic signed [COMP_W-1:0] dy;
  logic [ANGLE_W-1:0]       da;
  logic                     rot_cw;
  stage_t                   curr_next;

  always_comb begin
    dx     = prev.cy >>> step;   // arithmetic shift floors
    dy     = prev.cx >>> step;
    da     = step_angle(step);
    rot_cw = !prev.cy[COMP_W-1];
    curr_next = prev;
    curr_next.valid = prev.valid && !rst;
    if (!prev.special) begin
      if (rot_cw) begin
        curr_next.cx = prev.cx + dx;
        curr_next.cy = prev.cy - dy;
        curr_next.z  = prev.z + da;
      end else begin
        curr_next.cx = prev.cx - dx;
        curr_next.cy = prev.cy + dy;
        curr_next.z  = prev.z - da;
      end
    end
  end

  always_ff @(posedge clk) begin
    curr <= curr_next;
  end

endmodule

@@ hw/rtl/vector_angle_unit_top.sv @@
// ----------------------------------------------------------------------------
// vector_angle_unit_top
// Four-quadrant direction angle of a 2D vector as a 16-bit binary angle,
// built as a chain of CORDIC vectoring cells.
// ----------------------------------------------------------------------------
//
//  channel   ports                          handshake
//  -------   -----------------------------  ------------------------------
//  request   x_coord, y_coord               start high and busy low
//  result    angle_turns                    done high for one cycle
//
//  A request passes through one entry stage, one registered cell per
//  micro-rotation and one rounding register.
//  A new request enters every cycle; busy is always low since every cell
//  hands its contents on each clock.
//  rst (synchronous) clears only the valid bits of the chain; data
//  registers are left as they are.
//  The receiver cannot stall, so results leave on a fixed schedule.
// ----------------------------------------------------------------------------
module vector_angle_unit_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [vau_pkg::COORD_W-1:0]  x_coord,
  input  logic signed [vau_pkg::COORD_W-1:0]  y_coord,
  output logic                                done,
  output logic [vau_pkg::TURN_W-1:0]          angle_turns
);
  import vau_pkg::*;

  // stages[0] is the entry register, stages[k+1] the output of cell k.
  stage_t             stages [0:NUM_STEPS];
  logic [ANGLE_W-1:0] rounded;

  assign busy = 1'b0;

  vau_prep u_prep (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .x_coord (x_coord),
    .y_coord (y_coord),
    .head    (stages[0])
  );

  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_cell
    vau_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .step (STEP_IDX_W'(k)),
      .prev (stages[k]),
      .curr (stages[k+1])
    );
  end

  // Round half up to 16 bits; the 32-bit add wraps a full turn to 0.
  assign rounded = stages[NUM_STEPS].z + ROUND_HALF;

  always_ff @(posedge clk) begin
    angle_turns <= rounded[ANGLE_W-1 -: TURN_W];
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stages[NUM_STEPS].valid;
    end
  end

  // Every accepted request yields a result.
  a_req_to_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted request produced no result");

  // No result without an earlier request.
  a_result_has_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !rst, LATENCY))
    else $error("result without a matching request");

  // Zero vector gives angle 0.
  a_zero_vector: assert property (@(posedge clk) disable iff (rst)
    (start && x_coord == '0 && y_coord == '0) |-> ##LATENCY (angle_turns == ANGLE_ZERO))
    else $error("zero vector angle wrong");

  // Negative x axis gives a half turn.
  a_neg_x_axis: assert property (@(posedge clk) disable iff (rst)
    (start && x_coord[COORD_W-1] && y_coord == '0) |-> ##LATENCY
      (angle_turns == ANGLE_HALF))
    else $error("negative x axis angle wrong");

endmodule
